/* design/sample_window_statistics_assert.svh */
// Assertion macros used by the checker in design/sws_checker.sv.
`ifndef SAMPLE_WINDOW_STATISTICS_ASSERT_SVH
`define SAMPLE_WINDOW_STATISTICS_ASSERT_SVH

// Same-cycle implication, skipped while reset is held.
`define SWS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sample window statistics check failed");

// Next-cycle implication, skipped while reset is held.
`define SWS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sample window statistics check failed");

`endif

/* design/sws_pkg.sv */
package sws_pkg;

    localparam int WINDOW_DEF = 16;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [15:0] MIN_SAMPLES_RST = 16'd1;

    localparam logic CMD_FEED  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // what to do with the ring word, which arrives in the cycle after the read
    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_OLD       = 3'd1;
    localparam logic [2:0] OP_ACC_FIRST = 3'd2;
    localparam logic [2:0] OP_ACC       = 3'd3;
    localparam logic [2:0] OP_CAND      = 3'd4;
    localparam logic [2:0] OP_CMP       = 3'd5;

    typedef struct packed {
        logic              command;
        logic signed [31:0] sample;
    } in_t;

    typedef struct packed {
        logic [15:0]        sample_count;
        logic [4:0]         filled_length;
        logic               stats_ready;
        logic               have_any;
        logic signed [31:0] mean_value;
        logic signed [31:0] median_value;
        logic signed [31:0] minimum_value;
        logic signed [31:0] maximum_value;
        logic signed [31:0] oldest_value;
        logic signed [31:0] newest_value;
    } out_t;

    typedef struct packed {
        logic       accept;
        logic       rd_en;
        logic [2:0] op;
        logic       check;
        logic       div_start;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic ready;
        logic any;
        logic div_busy;
        logic out_stall;
    } status_t;

endpackage

/* design/sws_div.sv */
module sws_div #(
    parameter int NW = 37,
    parameter int DW = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [NW-1:0] quotient
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   trial;
    logic          fits;

    // one quotient bit per cycle, restoring
    always_comb begin
        trial     = {rem_reg, q_reg[NW-1]};
        fits      = trial >= {1'b0, divisor};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            rem_next  = '0;
            q_next    = dividend;
        end else if (busy_reg) begin
            rem_next  = fits ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
            q_next    = {q_reg[NW-2:0], fits};
            cnt_next  = cnt_reg - CW'(1);
            busy_next = cnt_reg != CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

/* design/sws_dp.sv */
module sws_dp #(
    parameter int WINDOW = sws_pkg::WINDOW_DEF,
    parameter int AW = $clog2(WINDOW),
    parameter int LW = $clog2(WINDOW + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_write,
    input  logic [15:0]      cfg_data,
    input  sws_pkg::in_t     s_item,
    input  sws_pkg::cmd_t    cmd,
    input  logic [AW-1:0]    rd_addr,
    output sws_pkg::status_t sts,
    output logic [AW-1:0]    last_idx,
    output logic             m_valid,
    input  logic             m_ready,
    output sws_pkg::out_t    m_result
);

    localparam int SW = 33 + AW;

    logic signed [31:0] ring_mem [WINDOW];

    logic [15:0]        min_samples_reg;
    logic [15:0]        fed_count_reg;
    logic [AW-1:0]      write_slot_reg;
    logic signed [31:0] newest_reg, oldest_reg, rd_data_reg;
    logic signed [31:0] min_reg, max_reg, cand_reg, lo_reg, hi_reg;
    logic signed [SW-1:0] sum_reg;
    logic [LW-1:0]      lt_reg, eq_reg;
    logic [2:0]         op_reg;
    logic               sum_neg_reg;
    logic               m_valid_reg;
    sws_pkg::out_t      m_result_reg, m_result_next;

    logic [AW-1:0]      next_slot, oldest_slot, rd_addr_eff;
    logic [LW-1:0]      len, k_lo, k_hi;
    logic [LW:0]        lt_eq;
    logic [15:0]        need;
    logic               ready, any;
    logic [SW-1:0]      sum_mag, quotient;
    logic signed [32:0] med_sum, med_adj;
    logic signed [31:0] mean_v, median_v;
    logic               div_busy;

    assign next_slot = (write_slot_reg == AW'(WINDOW - 1)) ? '0 : write_slot_reg + AW'(1);
    assign len = (fed_count_reg > 16'(WINDOW)) ? LW'(WINDOW) : fed_count_reg[LW-1:0];
    assign need  = (min_samples_reg == '0) ? 16'd1 : min_samples_reg;
    assign ready = fed_count_reg >= need;
    assign any   = fed_count_reg != '0;
    assign oldest_slot = (fed_count_reg < 16'(WINDOW)) ? '0 : next_slot;
    assign rd_addr_eff = (cmd.op == sws_pkg::OP_OLD) ? oldest_slot : rd_addr;
    assign last_idx = AW'(len - LW'(1));
    assign k_lo  = (len - LW'(1)) >> 1;
    assign k_hi  = len >> 1;
    assign lt_eq = {1'b0, lt_reg} + {1'b0, eq_reg};

    // sum magnitude for the unsigned divider; sign restored afterwards
    assign sum_mag = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);

    sws_div #(.NW(SW), .DW(LW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_mag),
        .divisor  (len),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign mean_v  = sum_neg_reg ? 32'(-quotient[31:0]) : quotient[31:0];
    assign med_sum = 33'(lo_reg) + 33'(hi_reg);
    assign med_adj = med_sum + 33'(med_sum[32]);
    assign median_v = med_adj[32:1];

    always_comb begin
        m_result_next.sample_count  = fed_count_reg;
        m_result_next.filled_length = 5'(len);
        m_result_next.stats_ready   = ready;
        m_result_next.have_any      = any;
        m_result_next.mean_value    = ready ? mean_v : '0;
        m_result_next.median_value  = ready ? median_v : '0;
        m_result_next.minimum_value = ready ? min_reg : '0;
        m_result_next.maximum_value = ready ? max_reg : '0;
        m_result_next.oldest_value  = any ? oldest_reg : '0;
        m_result_next.newest_value  = any ? newest_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_item.command == sws_pkg::CMD_FEED) begin
            ring_mem[next_slot] <= s_item.sample;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= ring_mem[rd_addr_eff];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_samples_reg <= sws_pkg::MIN_SAMPLES_RST;
            fed_count_reg   <= '0;
            write_slot_reg  <= AW'(WINDOW - 1);
            op_reg          <= sws_pkg::OP_NONE;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_write) begin
                min_samples_reg <= cfg_data;
            end
            if (cmd.accept) begin
                if (s_item.command == sws_pkg::CMD_CLEAR) begin
                    fed_count_reg  <= '0;
                    write_slot_reg <= AW'(WINDOW - 1);
                end else begin
                    write_slot_reg <= next_slot;
                    if (fed_count_reg != sws_pkg::COUNT_MAX) begin
                        fed_count_reg <= fed_count_reg + 16'd1;
                    end
                end
            end
            op_reg <= cmd.rd_en ? cmd.op : sws_pkg::OP_NONE;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            newest_reg <= s_item.sample;
        end
        case (op_reg)
            sws_pkg::OP_OLD: begin
                oldest_reg <= rd_data_reg;
            end
            sws_pkg::OP_ACC_FIRST: begin
                sum_reg <= SW'(rd_data_reg);
                min_reg <= rd_data_reg;
                max_reg <= rd_data_reg;
            end
            sws_pkg::OP_ACC: begin
                sum_reg <= sum_reg + SW'(rd_data_reg);
                if (rd_data_reg < min_reg) min_reg <= rd_data_reg;
                if (rd_data_reg > max_reg) max_reg <= rd_data_reg;
            end
            sws_pkg::OP_CAND: begin
                cand_reg <= rd_data_reg;
                lt_reg   <= '0;
                eq_reg   <= '0;
            end
            sws_pkg::OP_CMP: begin
                if (rd_data_reg < cand_reg) begin
                    lt_reg <= lt_reg + LW'(1);
                end else if (rd_data_reg == cand_reg) begin
                    eq_reg <= eq_reg + LW'(1);
                end
            end
            default: begin
            end
        endcase
        if (cmd.check) begin
            // candidate holds every rank from lt up to lt+eq-1
            if ({1'b0, lt_reg} <= {1'b0, k_lo} && {1'b0, k_lo} < lt_eq) lo_reg <= cand_reg;
            if ({1'b0, lt_reg} <= {1'b0, k_hi} && {1'b0, k_hi} < lt_eq) hi_reg <= cand_reg;
        end
        if (cmd.div_start) begin
            sum_neg_reg <= sum_reg[SW-1];
        end
        if (cmd.out_load) begin
            m_result_reg <= m_result_next;
        end
    end

    assign sts.ready     = ready;
    assign sts.any       = any;
    assign sts.div_busy  = div_busy;
    assign sts.out_stall = m_valid_reg && !m_ready;
    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

/* design/sws_ctrl.sv */
module sws_ctrl #(
    parameter int WINDOW = sws_pkg::WINDOW_DEF,
    parameter int AW = $clog2(WINDOW)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  sws_pkg::status_t sts,
    input  logic [AW-1:0]    last_idx,
    output sws_pkg::cmd_t    cmd,
    output logic [AW-1:0]    rd_addr
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_PREP    = 4'd1;
    localparam logic [3:0] ST_OLDW    = 4'd2;
    localparam logic [3:0] ST_SCAN    = 4'd3;
    localparam logic [3:0] ST_SDRAIN  = 4'd4;
    localparam logic [3:0] ST_DIVGO   = 4'd5;
    localparam logic [3:0] ST_SWEEP   = 4'd6;
    localparam logic [3:0] ST_MDRAIN  = 4'd7;
    localparam logic [3:0] ST_CHECK   = 4'd8;
    localparam logic [3:0] ST_WAITDIV = 4'd9;
    localparam logic [3:0] ST_FINISH  = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] i_reg, i_next, j_reg, j_next;

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd        = '0;
        cmd.op     = sws_pkg::OP_NONE;
        rd_addr    = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                i_next = '0;
                if (sts.any) begin
                    cmd.rd_en  = 1'b1;
                    cmd.op     = sws_pkg::OP_OLD;
                    state_next = ST_OLDW;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_OLDW: begin
                state_next = sts.ready ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                rd_addr   = i_reg;
                cmd.op    = (i_reg == '0) ? sws_pkg::OP_ACC_FIRST : sws_pkg::OP_ACC;
                if (i_reg == last_idx) begin
                    state_next = ST_SDRAIN;
                end else begin
                    i_next = i_reg + AW'(1);
                end
            end
            ST_SDRAIN: begin
                state_next = ST_DIVGO;
            end
            ST_DIVGO: begin
                cmd.div_start = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.op        = sws_pkg::OP_CAND;
                i_next        = '0;
                j_next        = '0;
                state_next    = ST_SWEEP;
            end
            ST_SWEEP: begin
                cmd.rd_en = 1'b1;
                rd_addr   = j_reg;
                cmd.op    = sws_pkg::OP_CMP;
                if (j_reg == last_idx) begin
                    state_next = ST_MDRAIN;
                end else begin
                    j_next = j_reg + AW'(1);
                end
            end
            ST_MDRAIN: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                if (i_reg == last_idx) begin
                    state_next = ST_WAITDIV;
                end else begin
                    i_next     = i_reg + AW'(1);
                    j_next     = '0;
                    cmd.rd_en  = 1'b1;
                    rd_addr    = i_reg + AW'(1);
                    cmd.op     = sws_pkg::OP_CAND;
                    state_next = ST_SWEEP;
                end
            end
            ST_WAITDIV: begin
                if (!sts.div_busy) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!sts.out_stall) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

endmodule

/* design/sample_window_statistics.sv */
// Flow per transaction: on an empty window the result loads without reading the ring; when
// statistics are not ready, only the oldest entry is read; with statistics ready, the filled
// entries are scanned, then the median rank search runs with the mean divider working beside
// it. Throughput: one transaction at a time; the next is accepted at the edge after the result
// loads, later while an unread result holds the output.
// Reset (aresetn, synchronous, active low): window empty, min_samples = 1, no result.
module sample_window_statistics #(
    parameter int WINDOW = sws_pkg::WINDOW_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sws_pkg::in_t  s_item,
    output logic          m_valid,
    input  logic          m_ready,
    output sws_pkg::out_t m_result,
    input  logic          cfg_write,
    input  logic [15:0]   cfg_data
);

    // ring address and filled-length widths
    localparam int AW = $clog2(WINDOW);
    localparam int LW = $clog2(WINDOW + 1);

    sws_pkg::cmd_t    cmd;
    sws_pkg::status_t sts;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    last_idx;

    // Controller: accept a transaction, read the oldest entry if there is one, and
    // if statistics are ready scan the filled entries for sum, minimum and maximum,
    // start the divider and walk every candidate against every entry to find the
    // middle ranks. Hold the finished result until the output register is free.
    sws_ctrl #(.WINDOW(WINDOW), .AW(AW)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .sts      (sts),
        .last_idx (last_idx),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    // Datapath: sample ring, counters, accumulators, rank counters, divider and
    // the output register that parts the result side from the input side.
    sws_dp #(.WINDOW(WINDOW), .AW(AW), .LW(LW)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .s_item    (s_item),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .sts       (sts),
        .last_idx  (last_idx),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

endmodule

/* design/sws_checker.sv */
`include "sample_window_statistics_assert.svh"

module sws_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          m_valid,
    input logic          m_ready,
    input sws_pkg::out_t m_result
);

    `SWS_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid)
    `SWS_ASSERT_IMPL(a_ready_has_any, aclk, aresetn, m_valid && m_result.stats_ready, m_result.have_any)
    `SWS_ASSERT_IMPL(a_empty_zero, aclk, aresetn, m_valid && !m_result.have_any, m_result.sample_count == '0 && m_result.filled_length == '0 && m_result.oldest_value == '0 && m_result.newest_value == '0)
    `SWS_ASSERT_IMPL(a_not_ready_zero, aclk, aresetn, m_valid && !m_result.stats_ready, m_result.mean_value == '0 && m_result.median_value == '0 && m_result.minimum_value == '0 && m_result.maximum_value == '0)

endmodule

bind sample_window_statistics sws_checker u_sws_checker (.*);

/* verif/sample_window_statistics_checker.sv */
// Watches both channels of the window statistics block, predicts each
// result and compares the whole result struct against it.
module sample_window_statistics_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  sws_pkg::in_t  s_item,
    input  logic          m_valid,
    input  logic          m_ready,
    input  sws_pkg::out_t m_result,
    input  logic          cfg_write,
    input  logic [15:0]   cfg_data,
    output int            fail_count,
    output int            pending_results,
    output int            results_seen
);

    localparam int WIN = sws_pkg::WINDOW_DEF;

    logic signed [31:0] window_copy [WIN];
    logic [3:0]         slot_copy;
    logic [15:0]        count_copy;
    logic [15:0]        need_copy;
    sws_pkg::out_t      expected_results [$];

    function automatic sws_pkg::out_t predict_window(input sws_pkg::in_t item);
        sws_pkg::out_t      r;
        logic signed [31:0] sorted [WIN];
        logic signed [31:0] v;
        logic signed [63:0] sum;
        logic [15:0]        need;
        int                 len;
        int                 j;
        r = '0;
        if (item.command == sws_pkg::CMD_CLEAR) begin
            count_copy = '0;
            slot_copy = 4'(WIN - 1);
        end else begin
            slot_copy = slot_copy + 4'd1;
            window_copy[slot_copy] = item.sample;
            if (count_copy != sws_pkg::COUNT_MAX) count_copy = count_copy + 16'd1;
        end
        len = (count_copy > WIN) ? WIN : int'(count_copy);
        need = (need_copy == 16'd0) ? 16'd1 : need_copy;
        r.sample_count = count_copy;
        r.filled_length = 5'(len);
        r.stats_ready = (count_copy >= need);
        r.have_any = (count_copy != 16'd0);
        if (r.stats_ready && len > 0) begin
            sum = '0;
            r.minimum_value = window_copy[0];
            r.maximum_value = window_copy[0];
            for (int i = 0; i < len; i++) begin
                v = window_copy[i];
                sum += 64'(v);
                if (v < r.minimum_value) r.minimum_value = v;
                if (v > r.maximum_value) r.maximum_value = v;
                // insertion sort for the median
                j = i;
                while (j > 0 && sorted[j - 1] > v) begin
                    sorted[j] = sorted[j - 1];
                    j--;
                end
                sorted[j] = v;
            end
            r.mean_value = 32'(sum / 64'(len));
            if (len % 2 == 0)
                r.median_value = 32'((64'(sorted[len / 2 - 1]) + 64'(sorted[len / 2])) / 2);
            else
                r.median_value = sorted[(len - 1) / 2];
        end
        if (r.have_any) begin
            r.oldest_value = (count_copy < WIN) ? window_copy[0] : window_copy[slot_copy + 4'd1];
            r.newest_value = window_copy[slot_copy];
        end
        return r;
    endfunction

    assign pending_results = expected_results.size();

    always @(posedge aclk) begin
        sws_pkg::out_t exp_r;
        if (!aresetn) begin
            count_copy <= '0;
            slot_copy <= 4'(WIN - 1);
            need_copy <= sws_pkg::MIN_SAMPLES_RST;
            expected_results.delete();
            fail_count <= 0;
            results_seen <= 0;
        end else begin
            if (cfg_write) need_copy <= cfg_data;
            if (s_valid && s_ready) expected_results.push_back(predict_window(s_item));
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %p", m_result);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== m_result) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p", exp_r, m_result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* verif/sample_window_statistics_test.sv */
// Top of the window statistics test: generate stimulus, apply back-pressure,
// and report the verdict from the checker's failure and pending counts.
module sample_window_statistics_test;

    localparam int RANDOM_ITEMS = 1850;
    localparam int CYCLE_LIMIT = 4000000;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    sws_pkg::in_t  s_item = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    sws_pkg::out_t m_result;
    logic          cfg_write = 1'b0;
    logic [15:0]   cfg_data = '0;
    int            fail_count;
    int            pending_results;
    int            results_seen;
    int            cycle_count = 0;
    int            transactions_sent = 0;
    bit            sink_quiet = 1'b0;   // last part of the run: no receiver stalls
    bit            hold_off_request = 1'b0;
    bit            hold_off_done = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sample_window_statistics DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_result(m_result),
        .cfg_write(cfg_write), .cfg_data(cfg_data)
    );

    sample_window_statistics_checker checker_inst (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_result(m_result),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_results(pending_results),
        .results_seen(results_seen)
    );

    // Timeout watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial begin
        int burst;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off_request) begin
                m_ready <= 1'b0;
                repeat (2000) @(posedge aclk);
                hold_off_request = 1'b0;
            end else if (!sink_quiet && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 18);
                m_ready <= 1'b0;
                repeat (burst) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    // Offer one transaction and hold it until accepted.
    task automatic send_sample(input logic cmd, input logic signed [31:0] value);
        s_item <= '{command: cmd, sample: value};
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        transactions_sent++;
    endtask

    // Drop valid and wait for every expected result, then settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_min_samples(input logic [15:0] value);
        drain_results();
        cfg_data <= value;
        cfg_write <= 1'b1;
        @(posedge aclk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_sample(input int style);
        case (style)
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(0, 20)) - 32'd10);
            default: return $signed($urandom());
        endcase
    endfunction

    initial begin
        int phase_len;
        logic signed [31:0] extremes [4];
        extremes = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, -32'sd1};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: clear on empty, both extremes, even and odd lengths, wrap.
        send_sample(sws_pkg::CMD_CLEAR, 32'sh5A5A5A5A);
        for (int i = 0; i < 18; i++) send_sample(sws_pkg::CMD_FEED, extremes[i % 4]);
        send_sample(sws_pkg::CMD_CLEAR, '0);
        send_sample(sws_pkg::CMD_FEED, 32'sh7FFFFFFF);
        send_sample(sws_pkg::CMD_FEED, 32'sh7FFFFFFF);
        write_min_samples(16'd0);
        send_sample(sws_pkg::CMD_FEED, 32'sh80000000);
        send_sample(sws_pkg::CMD_CLEAR, '0);
        send_sample(sws_pkg::CMD_FEED, -32'sd3);

        // Random phases; each phase picks a min_samples setting.
        // Hold off the receiver once mid-run so the block backs up.
        while (transactions_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0: write_min_samples(16'd0);
                1: write_min_samples(16'hFFFF);
                2: write_min_samples(16'($urandom_range(1, 20)));
                default: write_min_samples(16'd1);
            endcase
            if (!hold_off_done && transactions_sent > 600) begin
                hold_off_request = 1'b1;
                hold_off_done = 1'b1;
            end
            if (transactions_sent > RANDOM_ITEMS - 200) sink_quiet = 1'b1;
            phase_len = $urandom_range(20, 120);
            for (int i = 0; i < phase_len; i++) begin
                if (!sink_quiet && $urandom_range(0, 7) == 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 18)) @(posedge aclk);
                end
                send_sample(($urandom_range(0, 40) == 0) ? sws_pkg::CMD_CLEAR
                                                         : sws_pkg::CMD_FEED,
                            pick_sample($urandom_range(0, 5)));
            end
        end
        drain_results();
        repeat (400) @(posedge aclk);

        $display("covered %0d transactions, %0d results, min_samples 0/1/small/max",
                 transactions_sent, results_seen);
        $display("with window wrap, clears, extreme samples and a long receiver hold-off");
        if (fail_count == 0 && pending_results == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
